// ===== src/ddalr_pkg.sv =====
// Shared types for the clipped DDA line rasterizer: request and response
// words, controller states, and the controller/datapath command and status bundles.
// No dependencies.
package ddalr_pkg;

   localparam int COORD_W  = 6;
   localparam int OFFSET_W = 15;
   localparam int COLOR_W  = 32;

   localparam int MAPDIM_W = 7;
   localparam int ROWB_W   = 10;
   localparam int BPP_W    = 4;
   localparam int CSR_W    = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 3'd3;

   localparam logic [ROWB_W-1:0] ROW_BYTES_RESET = 10'd256;
   localparam logic [BPP_W-1:0]  BPP_RESET       = 4'd4;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  pix_x;
      logic [COORD_W-1:0]  pix_y;
      logic                write_enable;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COLOR_W-1:0]  out_color;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [MAPDIM_W-1:0] map_width;
      logic [MAPDIM_W-1:0] map_height;
      logic [ROWB_W-1:0]   row_bytes;
      logic [BPP_W-1:0]    bytes_per_pixel;
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic steps_one;
      logic pix_pending;
   } status_type;

endpackage

// ===== src/dda_line_raster_clipped_core.sv =====
// Top level of the clipped DDA line rasterizer: configuration registers,
// sequencer and datapath. Depends on ddalr_pkg, ddalr_ctrl, ddalr_datapath.
//
//   channel   ports                                   handshake
//   request   start, busy, req_word                   taken when start && !busy
//   response  rsp_strobe, rsp_word                    one word per strobe, no stall
//   config    csr_write_enable, csr_index, csr_write_data   taken when enable high
//
// The serial restoring dividers produce one quotient bit per cycle, then the
// accumulators take a single step per pixel while busy stays high. Each word is
// registered in pix_valid_ff and then in rsp_ff and rsp_strobe_ff after its step.
// A zero-length line holds busy through the divide and yields no word. Reset is
// synchronous and restores the register defaults.
module dda_line_raster_clipped_core #(
   parameter int MAP_SIZE  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  ddalr_pkg::req_type                   req_word,
   output logic                                 rsp_strobe,
   output ddalr_pkg::rsp_type                   rsp_word,
   input  logic                                 csr_write_enable,
   input  logic [ddalr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddalr_pkg::CSR_W-1:0]          csr_write_data
);
   import ddalr_pkg::*;

   // every coordinate is below 64, so any larger map size clips nothing
   localparam int MAP_RESET_I = (MAP_SIZE > 64) ? 64 : MAP_SIZE;
   localparam logic [MAPDIM_W-1:0] MAP_RESET = MAPDIM_W'(MAP_RESET_I);

   csr_type    csr_ff;
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.map_width       <= MAP_RESET;
         csr_ff.map_height      <= MAP_RESET;
         csr_ff.row_bytes       <= ROW_BYTES_RESET;
         csr_ff.bytes_per_pixel <= BPP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAP_WIDTH:       csr_ff.map_width       <= csr_write_data[MAPDIM_W-1:0];
            CSR_MAP_HEIGHT:      csr_ff.map_height      <= csr_write_data[MAPDIM_W-1:0];
            CSR_ROW_BYTES:       csr_ff.row_bytes       <= csr_write_data[ROWB_W-1:0];
            CSR_BYTES_PER_PIXEL: csr_ff.bytes_per_pixel <= csr_write_data[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   ddalr_ctrl #(
      .FRAC_BITS(FRAC_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   ddalr_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .csr        (csr_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== src/ddalr_ctrl.sv =====
// Sequencer for the line rasterizer: accept, serial divide, step run.
// Depends on ddalr_pkg.
module ddalr_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output ddalr_pkg::cmd_type    cmd,
   input  ddalr_pkg::status_type status
);
   import ddalr_pkg::*;

   localparam int DIV_CYCLES = FRAC_BITS + COORD_W;
   localparam int CNT_W      = $clog2(DIV_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             div_last;

   assign div_last = (cnt_ff == CNT_LAST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !status.pix_pending) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = status.steps_zero ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            if (status.steps_one) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      busy     = 1'b1;
      cnt_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            busy     = status.pix_pending;
            cmd.load = start && !status.pix_pending;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/ddalr_datapath.sv =====
// Datapath: end point capture, two restoring dividers for the increments,
// position accumulators and the registered pixel/offset output stage.
// Depends on ddalr_pkg.
module ddalr_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ddalr_pkg::req_type    req_word,
   input  ddalr_pkg::csr_type    csr,
   input  ddalr_pkg::cmd_type    cmd,
   output ddalr_pkg::status_type status,
   output logic                  rsp_strobe,
   output ddalr_pkg::rsp_type    rsp_word
);
   import ddalr_pkg::*;

   localparam int W = COORD_W + FRAC_BITS;

   logic [COORD_W-1:0] steps_ff, steps_left_ff, steps_left_in;
   logic [COORD_W-1:0] mag_x, mag_y, steps_new;
   logic               neg_x_ff, neg_y_ff;
   logic [COLOR_W-1:0] color_ff;

   logic [COORD_W-1:0] rem_x_ff, rem_y_ff;
   logic [W-1:0]       dq_x_ff, dq_y_ff;
   logic [COORD_W:0]   rem_x_sh, rem_y_sh;
   logic               ge_x, ge_y;

   logic [W-1:0]       acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;

   logic               pix_valid_ff, pix_last_ff;
   logic [COORD_W-1:0] px, py;
   logic [COORD_W+ROWB_W-1:0] row_part;
   logic [COORD_W+BPP_W-1:0]  col_part;
   logic [COORD_W+ROWB_W:0]   off_sum;
   rsp_type            rsp_ff;
   logic               rsp_strobe_ff;

   assign mag_x = (req_word.end_x >= req_word.start_x) ?
                  req_word.end_x - req_word.start_x : req_word.start_x - req_word.end_x;
   assign mag_y = (req_word.end_y >= req_word.start_y) ?
                  req_word.end_y - req_word.start_y : req_word.start_y - req_word.end_y;
   assign steps_new = (mag_x > mag_y) ? mag_x : mag_y;

   // one quotient bit per cycle on each axis, divisor is the step count
   assign rem_x_sh = {rem_x_ff, dq_x_ff[W-1]};
   assign rem_y_sh = {rem_y_ff, dq_y_ff[W-1]};
   assign ge_x     = rem_x_sh >= {1'b0, steps_ff};
   assign ge_y     = rem_y_sh >= {1'b0, steps_ff};

   // truncated increments never carry the position past the end point
   assign acc_x_in = neg_x_ff ? acc_x_ff - dq_x_ff : acc_x_ff + dq_x_ff;
   assign acc_y_in = neg_y_ff ? acc_y_ff - dq_y_ff : acc_y_ff + dq_y_ff;
   assign steps_left_in = steps_left_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steps_ff      <= steps_new;
         steps_left_ff <= steps_new;
         neg_x_ff      <= req_word.end_x < req_word.start_x;
         neg_y_ff      <= req_word.end_y < req_word.start_y;
         color_ff      <= req_word.pixel_color;
         rem_x_ff      <= '0;
         rem_y_ff      <= '0;
         dq_x_ff       <= {mag_x, {FRAC_BITS{1'b0}}};
         dq_y_ff       <= {mag_y, {FRAC_BITS{1'b0}}};
         acc_x_ff      <= {req_word.start_x, {FRAC_BITS{1'b0}}};
         acc_y_ff      <= {req_word.start_y, {FRAC_BITS{1'b0}}};
      end else if (cmd.div_step) begin
         rem_x_ff <= ge_x ? COORD_W'(rem_x_sh - {1'b0, steps_ff}) : rem_x_sh[COORD_W-1:0];
         rem_y_ff <= ge_y ? COORD_W'(rem_y_sh - {1'b0, steps_ff}) : rem_y_sh[COORD_W-1:0];
         dq_x_ff  <= {dq_x_ff[W-2:0], ge_x};
         dq_y_ff  <= {dq_y_ff[W-2:0], ge_y};
      end else if (cmd.step) begin
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         steps_left_ff <= steps_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff  <= 1'b0;
         pix_last_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pix_valid_ff  <= cmd.step;
         pix_last_ff   <= cmd.step && (steps_left_ff == COORD_W'(1));
         rsp_strobe_ff <= pix_valid_ff;
      end
   end

   assign px       = acc_x_ff[W-1:FRAC_BITS];
   assign py       = acc_y_ff[W-1:FRAC_BITS];
   assign row_part = py * csr.row_bytes;
   assign col_part = px * csr.bytes_per_pixel;
   assign off_sum  = {1'b0, row_part} + (COORD_W+ROWB_W+1)'(col_part);

   always_ff @(posedge clock) begin
      if (pix_valid_ff) begin
         rsp_ff.pix_x        <= px;
         rsp_ff.pix_y        <= py;
         rsp_ff.write_enable <= ({1'b0, px} < csr.map_width) && ({1'b0, py} < csr.map_height);
         rsp_ff.byte_offset  <= off_sum[OFFSET_W-1:0];
         rsp_ff.out_color    <= color_ff;
         rsp_ff.last         <= pix_last_ff;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_word           = rsp_ff;
   assign status.steps_zero  = (steps_ff == '0);
   assign status.steps_one   = (steps_left_ff == COORD_W'(1));
   assign status.pix_pending = pix_valid_ff;

endmodule

// ===== tb/dda_line_raster_clipped_core_test.sv =====
// Self-checking bench for dda_line_raster_clipped_core: directed and random lines
// under several map and framebuffer settings, each pixel word checked on arrival.
// Depends on ddalr_pkg and the core RTL.
`timescale 1ns / 1ps

module dda_line_raster_clipped_core_test;
   import ddalr_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   // shadow of the map and framebuffer registers
   logic [MAPDIM_W-1:0] map_w = 7'd64;
   logic [MAPDIM_W-1:0] map_h = 7'd64;
   logic [ROWB_W-1:0] row_b = ROW_BYTES_RESET;
   logic [BPP_W-1:0] pix_bytes = BPP_RESET;

   req_type line_queue[$];
   rsp_type pixel_queue[$];

   bit no_idle = 1'b0;
   int gap_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int lines_drawn = 0;
   int empty_lines = 0;
   int pixels_seen = 0;
   int clipped_seen = 0;
   int settings_used = 1;

   dda_line_raster_clipped_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int fixed_slope(int d, int n);
      int m;
      int q;
      m = d < 0 ? -d : d;
      q = (m << FRAC_BITS) / n;
      return d < 0 ? -q : q;
   endfunction

   function automatic logic [COORD_W-1:0] pixel_of(int acc);
      if (acc < 0) return '0;
      return COORD_W'(acc >>> FRAC_BITS);
   endfunction

   // step the line the way the rasterizer does and queue one word per pixel
   task automatic predict_line(input req_type line);
      int dx, dy, adx, ady, n, inc_x, inc_y, acc_x, acc_y, offset;
      rsp_type pixel;
      dx = int'(line.end_x) - int'(line.start_x);
      dy = int'(line.end_y) - int'(line.start_y);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      n = adx > ady ? adx : ady;
      lines_drawn++;
      if (n == 0) begin
         empty_lines++;
         return;
      end
      inc_x = fixed_slope(dx, n);
      inc_y = fixed_slope(dy, n);
      acc_x = int'(line.start_x) << FRAC_BITS;
      acc_y = int'(line.start_y) << FRAC_BITS;
      for (int k = 1; k <= n; k++) begin
         acc_x += inc_x;
         acc_y += inc_y;
         pixel.pix_x = pixel_of(acc_x);
         pixel.pix_y = pixel_of(acc_y);
         offset = int'(pixel.pix_y) * int'(row_b) + int'(pixel.pix_x) * int'(pix_bytes);
         pixel.byte_offset = offset[OFFSET_W-1:0];
         pixel.write_enable = (pixel.pix_x < map_w) && (pixel.pix_y < map_h);
         pixel.out_color = line.pixel_color;
         pixel.last = (k == n);
         pixel_queue.push_back(pixel);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   function automatic logic [COORD_W-1:0] clamp_coord(int v);
      if (v < 0) return '0;
      if (v > 63) return 6'd63;
      return COORD_W'(v);
   endfunction

   function automatic req_type make_line(int sx, int sy, int ex, int ey, logic [31:0] color);
      req_type line;
      line.start_x = COORD_W'(sx);
      line.start_y = COORD_W'(sy);
      line.end_x = COORD_W'(ex);
      line.end_y = COORD_W'(ey);
      line.pixel_color = color;
      return line;
   endfunction

   // mostly full-range lines, some short ones near the start point, a few of zero length
   function automatic req_type random_line();
      req_type line;
      int roll, jx, jy;
      roll = $urandom_range(0, 99);
      line.start_x = COORD_W'($urandom_range(0, 63));
      line.start_y = COORD_W'($urandom_range(0, 63));
      line.end_x = COORD_W'($urandom_range(0, 63));
      line.end_y = COORD_W'($urandom_range(0, 63));
      line.pixel_color = $urandom;
      if (roll < 10) begin
         line.end_x = line.start_x;
         line.end_y = line.start_y;
      end else if (roll < 35) begin
         jx = $urandom_range(0, 8);
         jy = $urandom_range(0, 8);
         line.end_x = clamp_coord(int'(line.start_x) + jx - 4);
         line.end_y = clamp_coord(int'(line.start_y) + jy - 4);
      end
      return line;
   endfunction

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // line driver: hold the word while busy, then idle or load the next line
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            // count the gap only once the core is ready again
            if (!start && !busy) gap_left <= gap_left - 1;
         end else if (line_queue.size() != 0) begin
            req_word <= line_queue.pop_front();
            start <= 1'b1;
            gap_left <= draw_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // pixel monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) predict_line(req_word);
         if (rsp_strobe) begin
            pixels_seen++;
            if (!rsp_word.write_enable) clipped_seen++;
            if (pixel_queue.size() == 0) begin
               $error("pixel word with no line pending: x=%0d y=%0d",
                      rsp_word.pix_x, rsp_word.pix_y);
               mismatches++;
            end else begin
               want = pixel_queue.pop_front();
               check_field("pix_x", want.pix_x, rsp_word.pix_x);
               check_field("pix_y", want.pix_y, rsp_word.pix_y);
               check_field("write_enable", want.write_enable, rsp_word.write_enable);
               check_field("byte_offset", want.byte_offset, rsp_word.byte_offset);
               check_field("out_color", want.out_color, rsp_word.out_color);
               check_field("last", want.last, rsp_word.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_MAP_WIDTH: map_w = value[MAPDIM_W-1:0];
         CSR_MAP_HEIGHT: map_h = value[MAPDIM_W-1:0];
         CSR_ROW_BYTES: row_b = value[ROWB_W-1:0];
         CSR_BYTES_PER_PIXEL: pix_bytes = value[BPP_W-1:0];
         default: ;
      endcase
   endtask

   // wait for every line to go in and every pixel to come out, then let the core settle
   task automatic drain();
      do @(posedge clock);
      while (line_queue.size() != 0 || start || pixel_queue.size() != 0 || busy);
      repeat (100) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] w, h, rb, bpp, input int count,
                            input bit burst);
      write_csr(CSR_MAP_WIDTH, w);
      write_csr(CSR_MAP_HEIGHT, h);
      write_csr(CSR_ROW_BYTES, rb);
      write_csr(CSR_BYTES_PER_PIXEL, bpp);
      // spare index must not disturb anything
      write_csr(CSR_SPARE, CSR_W'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
      no_idle = burst;
      repeat (count) line_queue.push_back(random_line());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes, octants, single steps and truncated minor axes
      line_queue.push_back(make_line(0, 0, 0, 0, 32'h0000_0000));
      line_queue.push_back(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
      line_queue.push_back(make_line(0, 0, 63, 63, 32'hFFFF_FFFF));
      line_queue.push_back(make_line(63, 63, 0, 0, 32'h0000_0000));
      line_queue.push_back(make_line(0, 0, 63, 0, 32'hAAAA_5555));
      line_queue.push_back(make_line(63, 63, 0, 63, 32'h5555_AAAA));
      line_queue.push_back(make_line(0, 0, 0, 63, 32'h1234_5678));
      line_queue.push_back(make_line(63, 63, 63, 0, 32'h8765_4321));
      line_queue.push_back(make_line(0, 0, 1, 0, 32'h0000_0001));
      line_queue.push_back(make_line(5, 5, 4, 6, 32'h8000_0000));
      line_queue.push_back(make_line(0, 63, 63, 0, 32'hDEAD_BEEF));
      line_queue.push_back(make_line(63, 0, 0, 63, 32'h0F0F_F0F0));
      line_queue.push_back(make_line(0, 0, 3, 63, 32'hCAFE_F00D));
      line_queue.push_back(make_line(63, 0, 0, 7, 32'h7FFF_FFFF));
      line_queue.push_back(make_line(10, 20, 50, 33, 32'hF0F0_0F0F));
      line_queue.push_back(make_line(1, 62, 62, 1, 32'h3333_CCCC));
      line_queue.push_back(make_line(0, 0, 63, 62, 32'hC3C3_3C3C));
      line_queue.push_back(make_line(32, 32, 31, 31, 32'h0001_0000));
      drain();

      run_phase(10'd1, 10'd1, 10'd1, 10'd1, 15, 1'b0);
      run_phase(10'd0, 10'd0, 10'd0, 10'd0, 12, 1'b0);
      // largest row pitch and pixel size: offsets wrap
      run_phase(10'd64, 10'd64, 10'd1023, 10'd15, 16, 1'b1);
      run_phase(CSR_W'($urandom_range(1, 64)), CSR_W'($urandom_range(1, 64)),
                CSR_W'($urandom_range(1, 512)), CSR_W'($urandom_range(1, 8)), 16, 1'b0);
      // raw data with the upper bits set: only the low register bits count
      run_phase(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                12, 1'b0);
      run_phase(10'd64, 10'd64, 10'd512, 10'd8, 16, 1'b1);
      run_phase(10'd32, 10'd16, 10'd256, 10'd4, 15, 1'b0);

      $display("Drew %0d lines (%0d of zero length) under %0d register settings.",
               lines_drawn, empty_lines, settings_used);
      $display("Checked %0d pixel words, %0d of them clipped.", pixels_seen, clipped_seen);
      if (mismatches == 0 && pixel_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/ddalr_pkg.sv
src/ddalr_ctrl.sv
src/ddalr_datapath.sv
src/dda_line_raster_clipped_core.sv
tb/dda_line_raster_clipped_core_test.sv
